// ===== src/euler_rotation_matrix_macros.svh =====
// Assertion macros for the rotation matrix RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef EULER_ROTATION_MATRIX_MACROS_SVH
`define EULER_ROTATION_MATRIX_MACROS_SVH
`define ERM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("lbl failed");
`define ERM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lbl failed");
`endif

// ===== src/erm_pkg.sv =====
// Package for the rotation matrix block: CORDIC constants and widths.
// Depends on nothing.
`default_nettype none
package erm_pkg;
  localparam int unsigned QW = 36;
  localparam int unsigned Steps = 32;
  localparam logic signed [QW-1:0] Pi30 = 36'sd3373259426;
  localparam logic signed [QW-1:0] HalfPi30 = 36'sd1686629713;
  localparam logic signed [QW-1:0] Gain30 = 36'sd652032874;

  typedef logic signed [QW-1:0] q30_t;

  function automatic q30_t atan_q30(input logic [4:0] i);
    unique case (i)
      5'd0: atan_q30 = 36'sh03243F6A8;  5'd1: atan_q30 = 36'sh01DAC6705;
      5'd2: atan_q30 = 36'sh00FADBAFC;  5'd3: atan_q30 = 36'sh007F56EA6;
      5'd4: atan_q30 = 36'sh003FEAB76;  5'd5: atan_q30 = 36'sh001FFD55B;
      5'd6: atan_q30 = 36'sh000FFFAAA;  5'd7: atan_q30 = 36'sh0007FFF55;
      5'd8: atan_q30 = 36'sh0003FFFEA;  5'd9: atan_q30 = 36'sh0001FFFFD;
      5'd10: atan_q30 = 36'sh0000FFFFF; 5'd11: atan_q30 = 36'sh00007FFFF;
      5'd12: atan_q30 = 36'sh00003FFFF; 5'd13: atan_q30 = 36'sh00001FFFF;
      5'd14: atan_q30 = 36'sh00000FFFF; 5'd15: atan_q30 = 36'sh000007FFF;
      5'd16: atan_q30 = 36'sh000003FFF; 5'd17: atan_q30 = 36'sh000001FFF;
      5'd18: atan_q30 = 36'sh000000FFF; 5'd19: atan_q30 = 36'sh0000007FF;
      5'd20: atan_q30 = 36'sh0000003FF; 5'd21: atan_q30 = 36'sh0000001FF;
      5'd22: atan_q30 = 36'sh0000000FF; 5'd23: atan_q30 = 36'sh00000007F;
      5'd24: atan_q30 = 36'sh00000003F; 5'd25: atan_q30 = 36'sh00000001F;
      5'd26: atan_q30 = 36'sh00000000F; 5'd27: atan_q30 = 36'sh000000008;
      5'd28: atan_q30 = 36'sh000000004; 5'd29: atan_q30 = 36'sh000000002;
      5'd30: atan_q30 = 36'sh000000001; default: atan_q30 = 36'sh000000000;
    endcase
  endfunction

  // Q.30 product rounded half up back to Q.30 (operands stay within about +/-2).
  function automatic q30_t mul30(input q30_t a, input q30_t b);
    logic signed [2*QW-1:0] p;
    p = a * b + (72'sd1 <<< 29);
    mul30 = QW'(p >>> 30);
  endfunction
endpackage
`default_nettype wire

// ===== src/erm_cordic_lane.sv =====
// One sine/cosine lane: range reduction, quadrant fold and a 32-stage CORDIC.
// Depends on erm_pkg.
`default_nettype none
module erm_cordic_lane #(
  parameter int unsigned AW = 16
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [AW-1:0]     angle_i,
  output erm_pkg::q30_t          cos_o,
  output erm_pkg::q30_t          sin_o
);
  localparam int unsigned N = erm_pkg::Steps;
  // Input magnitude is below 8 rad, so at most two wraps by 2*pi are needed.
  localparam logic signed [erm_pkg::QW-1:0] TwoPi = erm_pkg::Pi30 <<< 1;

  erm_pkg::q30_t a0, a1, ared;
  logic flip_d;
  erm_pkg::q30_t x_q [N+1];
  erm_pkg::q30_t y_q [N+1];
  erm_pkg::q30_t z_q [N+1];
  logic flip_q [N+1];

  always_comb begin
    a0 = erm_pkg::QW'($signed(angle_i)) <<< (30 - (AW - 4));
    a1 = a0;
    if (a1 > erm_pkg::Pi30) a1 = a1 - TwoPi;
    if (a1 < -erm_pkg::Pi30) a1 = a1 + TwoPi;
    if (a1 > erm_pkg::Pi30) a1 = a1 - TwoPi;
    if (a1 < -erm_pkg::Pi30) a1 = a1 + TwoPi;
    ared = a1;
    flip_d = 1'b0;
    if (a1 > erm_pkg::HalfPi30) begin
      ared = a1 - erm_pkg::Pi30;
      flip_d = 1'b1;
    end else if (a1 < -erm_pkg::HalfPi30) begin
      ared = a1 + erm_pkg::Pi30;
      flip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= erm_pkg::Gain30;
      y_q[0] <= '0;
      z_q[0] <= ared;
      flip_q[0] <= flip_d;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[i+1] <= flip_q[i];
        if (!z_q[i][erm_pkg::QW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - erm_pkg::atan_q30(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + erm_pkg::atan_q30(5'(i));
        end
      end
    end
  end

  assign cos_o = flip_q[N] ? -x_q[N] : x_q[N];
  assign sin_o = flip_q[N] ? -y_q[N] : y_q[N];
endmodule
`default_nettype wire

// ===== src/erm_merge.sv =====
// Merging stage: combines the three lanes' sines and cosines into nine entries.
// Depends on erm_pkg.
`default_nettype none
module erm_merge #(
  parameter int unsigned EW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  erm_pkg::q30_t      cx_i, sx_i, cy_i, sy_i, cz_i, sz_i,
  output logic [EW-1:0]      m_o [9]
);
  erm_pkg::q30_t cx1, sx1, cy1, sy1, cz1, sz1, sxsy1, cxsy1;
  erm_pkg::q30_t p_q [13];
  erm_pkg::q30_t e_q [9];

  function automatic logic [EW-1:0] to_entry(input erm_pkg::q30_t v);
    erm_pkg::q30_t r, one;
    one = erm_pkg::q30_t'(1) <<< (EW - 2);
    if (EW - 2 < 30) r = (v + (erm_pkg::q30_t'(1) <<< (29 - (EW - 2)))) >>> (30 - (EW - 2));
    else r = v;
    if (r > one) r = one;
    if (r < -one) r = -one;
    to_entry = r[EW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx1 <= cx_i; sx1 <= sx_i; cy1 <= cy_i; sy1 <= sy_i; cz1 <= cz_i; sz1 <= sz_i;
      sxsy1 <= erm_pkg::mul30(sx_i, sy_i);
      cxsy1 <= erm_pkg::mul30(cx_i, sy_i);
      p_q[0] <= erm_pkg::mul30(cy1, cz1);
      p_q[1] <= erm_pkg::mul30(cy1, sz1);
      p_q[2] <= sy1;
      p_q[3] <= erm_pkg::mul30(sxsy1, cz1);
      p_q[4] <= erm_pkg::mul30(cx1, sz1);
      p_q[5] <= erm_pkg::mul30(cx1, cz1);
      p_q[6] <= erm_pkg::mul30(sxsy1, sz1);
      p_q[7] <= erm_pkg::mul30(sx1, cy1);
      p_q[8] <= erm_pkg::mul30(sx1, sz1);
      p_q[9] <= erm_pkg::mul30(cxsy1, cz1);
      p_q[10] <= erm_pkg::mul30(cxsy1, sz1);
      p_q[11] <= erm_pkg::mul30(sx1, cz1);
      p_q[12] <= erm_pkg::mul30(cx1, cy1);
      e_q[0] <= p_q[0];
      e_q[1] <= -p_q[1];
      e_q[2] <= p_q[2];
      e_q[3] <= p_q[3] + p_q[4];
      e_q[4] <= p_q[5] - p_q[6];
      e_q[5] <= -p_q[7];
      e_q[6] <= p_q[8] - p_q[9];
      e_q[7] <= p_q[10] + p_q[11];
      e_q[8] <= p_q[12];
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_out
    always_ff @(posedge clk_i) begin
      if (en_i) m_o[k] <= to_entry(e_q[k]);
    end
  end
endmodule
`default_nettype wire

// ===== src/euler_rotation_matrix.sv =====
// Euler X-Y-Z rotation matrix: three CORDIC lanes and a product/merge stage.
// Each beat passes the lane input register, the CORDIC stages, then the merge input, product, sum and entry registers.
// Throughput: one beat per cycle while unstalled; every CORDIC and product stage is a register.
// The whole pipeline stalls together while the output beat is not taken.
// Reset (rst_ni, async, active low) clears only the pipeline valid bits.
// Depends on erm_pkg, erm_cordic_lane, erm_merge and the macros header.
`default_nettype none
`include "euler_rotation_matrix_macros.svh"
module euler_rotation_matrix #(
  parameter int unsigned ANGLE_WIDTH = 16,
  parameter int unsigned ENTRY_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic signed [ANGLE_WIDTH-1:0] angle_x_i,
  input  wire logic signed [ANGLE_WIDTH-1:0] angle_y_i,
  input  wire logic signed [ANGLE_WIDTH-1:0] angle_z_i,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output logic signed [ENTRY_WIDTH-1:0]      m00_o, m01_o, m02_o,
  output logic signed [ENTRY_WIDTH-1:0]      m10_o, m11_o, m12_o,
  output logic signed [ENTRY_WIDTH-1:0]      m20_o, m21_o, m22_o
);
  localparam int unsigned Lat = erm_pkg::Steps + 5;

  logic [Lat-1:0] vld_q, vld_d;
  logic en;
  erm_pkg::q30_t c [3];
  erm_pkg::q30_t s [3];
  logic [ENTRY_WIDTH-1:0] m [9];

  // Pipeline advances whenever the last stage is empty or being drained.
  assign en = !vld_q[Lat-1] || ready_i;
  assign ready_o = en;
  assign valid_o = vld_q[Lat-1];
  assign vld_d = {vld_q[Lat-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  erm_cordic_lane #(.AW(ANGLE_WIDTH)) u_lane_x (
    .clk_i, .en_i(en), .angle_i(angle_x_i), .cos_o(c[0]), .sin_o(s[0]));
  erm_cordic_lane #(.AW(ANGLE_WIDTH)) u_lane_y (
    .clk_i, .en_i(en), .angle_i(angle_y_i), .cos_o(c[1]), .sin_o(s[1]));
  erm_cordic_lane #(.AW(ANGLE_WIDTH)) u_lane_z (
    .clk_i, .en_i(en), .angle_i(angle_z_i), .cos_o(c[2]), .sin_o(s[2]));

  erm_merge #(.EW(ENTRY_WIDTH)) u_merge (
    .clk_i, .en_i(en),
    .cx_i(c[0]), .sx_i(s[0]), .cy_i(c[1]), .sy_i(s[1]), .cz_i(c[2]), .sz_i(s[2]),
    .m_o(m));

  assign m00_o = m[0]; assign m01_o = m[1]; assign m02_o = m[2];
  assign m10_o = m[3]; assign m11_o = m[4]; assign m12_o = m[5];
  assign m20_o = m[6]; assign m21_o = m[7]; assign m22_o = m[8];

  `ERM_ASSERT(a_ready_when_empty, clk_i, rst_ni, !valid_o |-> ready_o)
  `ERM_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, valid_o && !ready_i,
                   valid_o && $stable(m00_o) && $stable(m22_o))
  `ERM_ASSERT(a_m02_range, clk_i, rst_ni,
              valid_o |-> ($signed(m02_o) <= $signed(ENTRY_WIDTH'(1) <<< (ENTRY_WIDTH-2))))
endmodule
`default_nettype wire

// ===== verif/euler_rotation_matrix_tb.sv =====
// Self-checking testbench for euler_rotation_matrix: random and corner angle triples,
// matrix entries predicted by a fixed-point CORDIC model and compared per beat.
// Depends on the euler_rotation_matrix RTL only.
`timescale 1ns / 1ps

class rotation_scoreboard;
  typedef logic signed [15:0] entry_t;
  typedef struct {
    entry_t m[9];
  } matrix_t;

  matrix_t pending[$];
  int errors = 0;

  static function longint floor_div(longint v, int s);
    return v >>> s;
  endfunction

  static function longint qmul(longint a, longint b);
    return floor_div(a * b + (64'sd1 <<< 29), 30);
  endfunction

  static function void sin_cos(logic signed [15:0] ang, output longint c, output longint s);
    longint a, x, y, z, dx, dy;
    bit flip;
    longint atan_tab[32] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
      'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
      'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
      'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
      'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
      'h00000001, 'h00000000};
    a = longint'(ang) * (64'sd1 <<< 18);
    flip = 0;
    while (a > 64'sd3373259426) a -= 64'sd6746518852;
    while (a < -64'sd3373259426) a += 64'sd6746518852;
    if (a > 64'sd1686629713) begin
      a -= 64'sd3373259426;
      flip = 1;
    end else if (a < -64'sd1686629713) begin
      a += 64'sd3373259426;
      flip = 1;
    end
    x = 64'sd652032874;
    y = 0;
    z = a;
    for (int i = 0; i < 32; i++) begin
      dx = floor_div(y, i);
      dy = floor_div(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  static function entry_t to_entry(longint v);
    v = floor_div(v + (64'sd1 <<< 15), 16);
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return entry_t'(v);
  endfunction

  function void note_angles(logic signed [15:0] ax, logic signed [15:0] ay,
                            logic signed [15:0] az);
    longint cx, sx, cy, sy, cz, sz, sxsy, cxsy;
    matrix_t r;
    sin_cos(ax, cx, sx);
    sin_cos(ay, cy, sy);
    sin_cos(az, cz, sz);
    sxsy = qmul(sx, sy);
    cxsy = qmul(cx, sy);
    r.m[0] = to_entry(qmul(cy, cz));
    r.m[1] = to_entry(-qmul(cy, sz));
    r.m[2] = to_entry(sy);
    r.m[3] = to_entry(qmul(sxsy, cz) + qmul(cx, sz));
    r.m[4] = to_entry(qmul(cx, cz) - qmul(sxsy, sz));
    r.m[5] = to_entry(-qmul(sx, cy));
    r.m[6] = to_entry(qmul(sx, sz) - qmul(cxsy, cz));
    r.m[7] = to_entry(qmul(cxsy, sz) + qmul(sx, cz));
    r.m[8] = to_entry(qmul(cx, cy));
    pending.push_back(r);
  endfunction

  function void check_matrix(entry_t got[9]);
    matrix_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected output beat", $time);
      errors++;
      return;
    end
    want = pending.pop_front();
    for (int k = 0; k < 9; k++)
      if (got[k] !== want.m[k]) begin
        $display("%0t: m%0d%0d expected %0d actual %0d", $time, k / 3, k % 3,
                 want.m[k], got[k]);
        errors++;
      end
  endfunction
endclass

module euler_rotation_matrix_tb;
  logic clk_i = 0;
  logic rst_ni = 0;
  logic valid_i = 0;
  logic ready_i = 0;
  logic signed [15:0] angle_x_i = 0, angle_y_i = 0, angle_z_i = 0;
  logic ready_o, valid_o;
  logic signed [15:0] m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o;

  rotation_scoreboard board = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 0;
  int quiet_cycles = 0;

  euler_rotation_matrix u_dut (
    .clk_i, .rst_ni, .valid_i, .ready_o, .angle_x_i, .angle_y_i, .angle_z_i,
    .valid_o, .ready_i, .m00_o, .m01_o, .m02_o, .m10_o, .m11_o, .m12_o,
    .m20_o, .m21_o, .m22_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Output side: check accepted beats, then pick the next cycle's ready.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && ready_i)
      board.check_matrix('{m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o});
    ready_i <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((valid_i && ready_o) || (valid_o && ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_angles(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az);
    // Valid drops only for the cycles in which the sender idles.
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 0;
      @(posedge clk_i);
    end
    valid_i <= 1;
    angle_x_i <= ax;
    angle_y_i <= ay;
    angle_z_i <= az;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    board.note_angles(ax, ay, az);
  endtask

  task automatic drain();
    valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_angle();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(25736)) - 12868);
      2: return 16'(int'($urandom_range(80)) - 40);
      default: return 16'(int'($urandom_range(160)) + 12788 - 80 * 2 * $urandom_range(1));
    endcase
  endfunction

  initial begin
    logic signed [15:0] corners[12] = '{16'sh0000, 16'sh7FFF, -16'sh8000, 16'sh0001,
      -16'sh0001, 16'sd12868, -16'sd12868, 16'sd6434, -16'sd6434, 16'sd25736,
      16'sh5555, -16'sh2AAB};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    foreach (corners[i])
      send_angles(corners[i], corners[(i + 3) % 12], corners[(i + 7) % 12]);
    for (int i = 0; i < 8; i++)
      send_angles(corners[$urandom_range(11)], corners[$urandom_range(11)],
                  corners[$urandom_range(11)]);
    drain();
    // Long receiver hold-off while the sender keeps offering beats.
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      repeat (80) send_angles(pick_angle(), pick_angle(), pick_angle());
    join
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 87 : 34) : 0;
      stall_pct = (phase == 2) ? 87 : (phase == 3 ? 34 : 0);
      repeat (210) send_angles(pick_angle(), pick_angle(), pick_angle());
      drain();
    end
    stall_pct = 0;
    repeat (60) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
